FILE: rtl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant violated");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

FILE: rtl/mlo_pkg.sv
// shared types, constants and helper functions of the mouse-look block
// no dependencies
package mlo_pkg;

  localparam int ANGLE_W = 25;
  localparam int PITCH_W = 24;
  localparam int TRIG_W = 32;
  localparam int WRAP_STEPS = 8;
  localparam int WRAP_IDX_W = 3;
  localparam int ATAN_ENTRIES = 24;

  localparam int YAW_HALF_TURN = 11796480;
  localparam int YAW_FULL_TURN = 23592960;
  localparam int PITCH_LIMIT = 5832704;
  localparam int QUARTER_TURN = 5898240;
  localparam int CORDIC_GAIN_Q30 = 652032874;
  localparam int YAW_RESET = -5898240;
  localparam int SENS_RESET = 6554;

  typedef struct packed {
    logic                  load_in;
    logic                  mul;
    logic                  sum;
    logic                  wrap_step;
    logic [WRAP_IDX_W-1:0] wrap_idx;
    logic                  yaw_set;
    logic                  trig_start;
    logic                  prod_x;
    logic                  prod_z;
    logic                  out_load;
  } cmd_t;

  typedef struct packed {
    logic trig_busy;
  } status_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [ANGLE_W-1:0] atan_at(input logic [4:0] i);
    logic signed [ANGLE_W-1:0] r;
    unique case (i)
      5'd0:  r = 25'sd2949120;
      5'd1:  r = 25'sd1740967;
      5'd2:  r = 25'sd919879;
      5'd3:  r = 25'sd466945;
      5'd4:  r = 25'sd234379;
      5'd5:  r = 25'sd117304;
      5'd6:  r = 25'sd58666;
      5'd7:  r = 25'sd29335;
      5'd8:  r = 25'sd14668;
      5'd9:  r = 25'sd7334;
      5'd10: r = 25'sd3667;
      5'd11: r = 25'sd1833;
      5'd12: r = 25'sd917;
      5'd13: r = 25'sd458;
      5'd14: r = 25'sd229;
      5'd15: r = 25'sd115;
      5'd16: r = 25'sd57;
      5'd17: r = 25'sd29;
      5'd18: r = 25'sd14;
      5'd19: r = 25'sd7;
      5'd20: r = 25'sd4;
      5'd21: r = 25'sd2;
      5'd22: r = 25'sd1;
      default: r = 25'sd0;
    endcase
    return r;
  endfunction

  // clamp to the q1.15 range
  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/mlo_cordic.sv
// iterative rotation-mode cordic, one micro-rotation per cycle
// depends on mlo_pkg (atan table, widths, gain)
module mlo_cordic #(
  parameter int ITERATIONS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [mlo_pkg::ANGLE_W-1:0]  angle,
  output logic                                busy,
  output logic signed [mlo_pkg::TRIG_W-1:0]   sin_q,
  output logic signed [mlo_pkg::TRIG_W-1:0]   cos_q
);

  localparam int STEPS = (ITERATIONS < mlo_pkg::ATAN_ENTRIES) ? ITERATIONS
                                                              : mlo_pkg::ATAN_ENTRIES;
  localparam int CW = $clog2(STEPS);
  localparam logic signed [mlo_pkg::ANGLE_W-1:0] QTR = mlo_pkg::ANGLE_W'(mlo_pkg::QUARTER_TURN);
  localparam logic signed [mlo_pkg::ANGLE_W-1:0] HALF = mlo_pkg::ANGLE_W'(2 * mlo_pkg::QUARTER_TURN);

  logic signed [mlo_pkg::TRIG_W-1:0]  x;
  logic signed [mlo_pkg::TRIG_W-1:0]  y;
  logic signed [mlo_pkg::ANGLE_W-1:0] z;
  logic                               flip;
  logic [CW-1:0]                      iter;

  logic signed [mlo_pkg::TRIG_W-1:0]  x_sh;
  logic signed [mlo_pkg::TRIG_W-1:0]  y_sh;
  logic signed [mlo_pkg::ANGLE_W-1:0] atan_i;

  // arithmetic shifts round toward minus infinity
  assign x_sh = x >>> iter;
  assign y_sh = y >>> iter;
  assign atan_i = mlo_pkg::atan_at(5'(iter));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= '0;
    end else if (busy) begin
      if (iter == CW'(STEPS - 1)) begin
        busy <= 1'b0;
      end
      iter <= iter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= mlo_pkg::TRIG_W'(mlo_pkg::CORDIC_GAIN_Q30);
      y <= '0;
      // fold into [-90, 90] degrees, negate the result later
      if (angle > QTR) begin
        z    <= angle - HALF;
        flip <= 1'b1;
      end else if (angle < -QTR) begin
        z    <= angle + HALF;
        flip <= 1'b1;
      end else begin
        z    <= angle;
        flip <= 1'b0;
      end
    end else if (busy) begin
      if (!z[mlo_pkg::ANGLE_W-1]) begin
        x <= x - y_sh;
        y <= y + x_sh;
        z <= z - atan_i;
      end else begin
        x <= x + y_sh;
        y <= y - x_sh;
        z <= z + atan_i;
      end
    end
  end

  assign sin_q = flip ? -y : y;
  assign cos_q = flip ? -x : x;

endmodule

FILE: rtl/mlo_datapath.sv
// angle state, sensitivity register, yaw wrap, two cordic units and output registers
// depends on mlo_pkg and mlo_cordic
module mlo_datapath #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  mlo_pkg::cmd_t       cmd,
  output mlo_pkg::status_t    status,
  input  logic                cfg_we,
  input  logic [15:0]         sensitivity,
  input  logic signed [15:0]  mouse_dx,
  input  logic signed [15:0]  mouse_dy,
  output logic signed [15:0]  forward_x,
  output logic signed [15:0]  forward_y,
  output logic signed [15:0]  forward_z,
  output logic signed [24:0]  yaw_now,
  output logic signed [23:0]  pitch_now
);

  localparam int AW = mlo_pkg::ANGLE_W;
  localparam int PW = mlo_pkg::PITCH_W;
  localparam int TW = mlo_pkg::TRIG_W;
  // bias that keeps the yaw sum non-negative before the modulo
  localparam longint WRAP_BIAS = longint'(mlo_pkg::YAW_HALF_TURN)
                               + 128 * longint'(mlo_pkg::YAW_FULL_TURN);
  localparam logic signed [33:0] P_HI = 34'(mlo_pkg::PITCH_LIMIT);
  localparam logic signed [33:0] P_LO = -34'(mlo_pkg::PITCH_LIMIT);

  logic [15:0]              sens;
  logic signed [15:0]       dx;
  logic signed [15:0]       dy;
  logic signed [32:0]       prod_dx;
  logic signed [32:0]       prod_dy;
  logic [32:0]              wrap_val;
  logic signed [AW-1:0]     yaw_angle;
  logic signed [PW-1:0]     pitch_angle;
  logic signed [63:0]       prod;
  logic signed [15:0]       fx_hold;

  logic signed [34:0]       yaw_sum;
  logic signed [33:0]       pitch_sum;
  logic [32:0]              wrap_sub;
  logic signed [64:0]       prod_rnd;
  logic signed [32:0]       sp_rnd;
  logic signed [15:0]       prod_sat;
  logic signed [15:0]       fy_sat;

  logic                     busy_y;
  logic                     busy_p;
  logic signed [TW-1:0]     sin_y;
  logic signed [TW-1:0]     cos_y;
  logic signed [TW-1:0]     sin_p;
  logic signed [TW-1:0]     cos_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      sens <= 16'(mlo_pkg::SENS_RESET);
    end else if (cfg_we) begin
      sens <= sensitivity;
    end
  end

  assign yaw_sum = 35'(yaw_angle) + 35'(prod_dx) + 35'(WRAP_BIAS);
  assign pitch_sum = 34'(pitch_angle) - 34'(prod_dy);
  assign wrap_sub = 33'(mlo_pkg::YAW_FULL_TURN) << cmd.wrap_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_angle   <= AW'(mlo_pkg::YAW_RESET);
      pitch_angle <= '0;
    end else begin
      if (cmd.sum) begin
        if (pitch_sum > P_HI) begin
          pitch_angle <= PW'(P_HI);
        end else if (pitch_sum < P_LO) begin
          pitch_angle <= PW'(P_LO);
        end else begin
          pitch_angle <= pitch_sum[PW-1:0];
        end
      end
      if (cmd.yaw_set) begin
        yaw_angle <= $signed(wrap_val[AW-1:0] - AW'(mlo_pkg::YAW_HALF_TURN));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dx <= mouse_dx;
      dy <= mouse_dy;
    end
    if (cmd.mul) begin
      prod_dx <= dx * $signed({1'b0, sens});
      prod_dy <= dy * $signed({1'b0, sens});
    end
    // restoring reduction, one power-of-two multiple of the full turn per step
    if (cmd.sum) begin
      wrap_val <= yaw_sum[32:0];
    end else if (cmd.wrap_step && (wrap_val >= wrap_sub)) begin
      wrap_val <= wrap_val - wrap_sub;
    end
  end

  mlo_cordic #(
    .ITERATIONS(TRIG_ITERATIONS)
  ) u_cordic_yaw (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.trig_start),
    .angle (yaw_angle),
    .busy  (busy_y),
    .sin_q (sin_y),
    .cos_q (cos_y)
  );

  mlo_cordic #(
    .ITERATIONS(TRIG_ITERATIONS)
  ) u_cordic_pitch (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.trig_start),
    .angle (AW'(pitch_angle)),
    .busy  (busy_p),
    .sin_q (sin_p),
    .cos_q (cos_p)
  );

  assign status.trig_busy = busy_y | busy_p;

  assign prod_rnd = 65'(prod) + (65'sd1 <<< 44);
  assign prod_sat = mlo_pkg::sat16(prod_rnd[64:45]);
  assign sp_rnd   = 33'(sin_p) + 33'sd16384;
  assign fy_sat   = mlo_pkg::sat16(20'($signed(sp_rnd[32:15])));

  always_ff @(posedge clk) begin
    if (cmd.prod_x) begin
      prod <= cos_y * cos_p;
    end else if (cmd.prod_z) begin
      prod <= sin_y * cos_p;
    end
    if (cmd.prod_z) begin
      fx_hold <= prod_sat;
    end
    if (cmd.out_load) begin
      forward_x <= fx_hold;
      forward_y <= fy_sat;
      forward_z <= prod_sat;
      yaw_now   <= yaw_angle;
      pitch_now <= pitch_angle;
    end
  end

endmodule

FILE: rtl/mlo_ctrl.sv
// sequencer for one mouse event: scale, wrap, trig, product, output
// depends on mlo_pkg (command and status structs)
module mlo_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  mlo_pkg::status_t  status,
  output mlo_pkg::cmd_t     cmd
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_MUL    = 10'b00_0000_0010,
    ST_SUM    = 10'b00_0000_0100,
    ST_WRAP   = 10'b00_0000_1000,
    ST_YAW    = 10'b00_0001_0000,
    ST_START  = 10'b00_0010_0000,
    ST_TRIG   = 10'b00_0100_0000,
    ST_PROD_X = 10'b00_1000_0000,
    ST_PROD_Z = 10'b01_0000_0000,
    ST_FINISH = 10'b10_0000_0000
  } state_t;

  state_t                         state;
  state_t                         state_next;
  logic [mlo_pkg::WRAP_IDX_W-1:0] wrap_cnt;
  logic                           out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.wrap_idx = wrap_cnt;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_WRAP;
      end
      ST_WRAP: begin
        cmd.wrap_step = 1'b1;
        if (wrap_cnt == '0) begin
          state_next = ST_YAW;
        end
      end
      ST_YAW: begin
        cmd.yaw_set = 1'b1;
        state_next  = ST_START;
      end
      ST_START: begin
        cmd.trig_start = 1'b1;
        state_next     = ST_TRIG;
      end
      ST_TRIG: begin
        if (!status.trig_busy) begin
          state_next = ST_PROD_X;
        end
      end
      ST_PROD_X: begin
        cmd.prod_x = 1'b1;
        state_next = ST_PROD_Z;
      end
      ST_PROD_Z: begin
        cmd.prod_z = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wrap_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_SUM) begin
        wrap_cnt <= mlo_pkg::WRAP_IDX_W'(mlo_pkg::WRAP_STEPS - 1);
      end else if (state == ST_WRAP) begin
        wrap_cnt <= wrap_cnt - 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/mouse_look_orientation.sv
// an input beat passes the scale, sum, yaw wrap, trig and product steps before the result is valid
// one event at a time, and a stalled output can hold the next; the pace is set by the iterative cordic
//   (one micro-rotation per cycle) plus eight yaw modulo steps and the shared multiplier
// a finished result sits in the output register while the next event is taken
// reset (rst, synchronous): yaw -90 degrees, pitch 0, sensitivity 6554, no result pending
// depends on mlo_pkg, mlo_ctrl, mlo_datapath, mlo_cordic
module mouse_look_orientation #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // sensitivity write channel, always ready
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        sensitivity,
  // mouse event channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] mouse_dx,
  input  logic signed [15:0] mouse_dy,
  // orientation result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] forward_x,
  output logic signed [15:0] forward_y,
  output logic signed [15:0] forward_z,
  output logic signed [24:0] yaw_now,
  output logic signed [23:0] pitch_now
);

  mlo_pkg::cmd_t    cmd;
  mlo_pkg::status_t status;

  // register writes must come only while idle (not enforced here); the port never pushes back
  assign cfg_ready = 1'b1;

  // controller: one-hot sequencer, input/output handshake
  mlo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: angle update, yaw wrap, two cordic units, products, output register
  mlo_datapath #(
    .TRIG_ITERATIONS(TRIG_ITERATIONS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_valid && cfg_ready),
    .sensitivity (sensitivity),
    .mouse_dx    (mouse_dx),
    .mouse_dy    (mouse_dy),
    .forward_x   (forward_x),
    .forward_y   (forward_y),
    .forward_z   (forward_z),
    .yaw_now     (yaw_now),
    .pitch_now   (pitch_now)
  );

endmodule

FILE: rtl/mlo_checker.sv
// port-level checks for the mouse-look block, bound to the top level
// depends on mlo_pkg and assert_macros.svh
`include "assert_macros.svh"

module mlo_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] forward_x,
  input logic signed [15:0] forward_y,
  input logic signed [15:0] forward_z,
  input logic signed [24:0] yaw_now,
  input logic signed [23:0] pitch_now
);

  // a stalled result beat holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(forward_x) && $stable(forward_y) && $stable(forward_z) && $stable(yaw_now) && $stable(pitch_now))

  // one event at a time: busy right after a beat is taken
  `ASSERT_NEXT(a_busy_after_in, clk, rst, in_valid && !in_stall, in_stall)

  // a new result appears as the sequencer returns to idle
  `ASSERT_IMPLIES(a_rise_idle, clk, rst, $rose(out_valid), !in_stall)

  // reported angles stay in their wrapped and clamped ranges
  `ASSERT_IMPLIES(a_pitch_range, clk, rst, out_valid, (pitch_now <= 24'sd5832704) && (pitch_now >= -24'sd5832704))
  `ASSERT_IMPLIES(a_yaw_range, clk, rst, out_valid, (yaw_now >= -25'(mlo_pkg::YAW_HALF_TURN)) && (yaw_now < 25'(mlo_pkg::YAW_HALF_TURN)))

endmodule

bind mouse_look_orientation mlo_checker u_mlo_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .forward_x (forward_x),
  .forward_y (forward_y),
  .forward_z (forward_z),
  .yaw_now   (yaw_now),
  .pitch_now (pitch_now)
);

FILE: tb/sv/mouse_look_orientation_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the mouse-look orientation block
// depends on mouse_look_orientation (and mlo_pkg beneath it); holds its own cordic predictor
module mouse_look_orientation_tb;

  localparam int TRIG_STEPS = 16;
  localparam int IDLE_LIMIT = 5000;   // cycles with no beat on any channel
  localparam int SETTLE_CYCLES = TRIG_STEPS + 24;

  // angle constants in 1/65536 degree
  localparam longint HALF_TURN = 64'sd11796480;
  localparam longint FULL_TURN = 64'sd23592960;
  localparam longint TILT_LIMIT = 64'sd5832704;
  localparam longint RIGHT_ANGLE = 64'sd5898240;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam int ATAN_LEN = 24;
  localparam longint ATAN_DEG [ATAN_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef enum {TX_STREAM, TX_BURSTY} tx_mode_t;
  typedef enum {RX_OPEN, RX_CHOPPY, RX_RUNS} rx_mode_t;

  typedef struct {
    logic signed [15:0] fwd_x;
    logic signed [15:0] fwd_y;
    logic signed [15:0] fwd_z;
    logic signed [24:0] yaw;
    logic signed [23:0] pitch;
  } view_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [15:0]        sens_wdata = 16'd0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] mouse_dx = 16'sd0;
  logic signed [15:0] mouse_dy = 16'sd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] forward_x;
  logic signed [15:0] forward_y;
  logic signed [15:0] forward_z;
  logic signed [24:0] yaw_now;
  logic signed [23:0] pitch_now;

  // predictor state: camera angles and the sensitivity it was last given
  longint cam_yaw;
  longint cam_pitch;
  longint cam_sens;
  view_t  pending_views [$];

  tx_mode_t tx_mode = TX_STREAM;
  rx_mode_t rx_mode = RX_OPEN;
  int burst_left = 0;
  int rx_run_left = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int events_sent = 0;
  int results_checked = 0;
  int sens_settings = 0;

  always #1 clk = ~clk;

  mouse_look_orientation #(
    .TRIG_ITERATIONS(TRIG_STEPS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .sensitivity(sens_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mouse_dx   (mouse_dx),
    .mouse_dy   (mouse_dy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .forward_x  (forward_x),
    .forward_y  (forward_y),
    .forward_z  (forward_z),
    .yaw_now    (yaw_now),
    .pitch_now  (pitch_now)
  );

  // rotation-mode cordic, q2.30, floor shifts; angles past +-90 fold back with a sign flip
  function automatic void cordic_sincos(input longint angle, output longint s,
                                        output longint c);
    longint x, y, z, step_x, step_y;
    bit     flip;
    x = GAIN_Q30;
    y = 0;
    z = angle;
    flip = 1'b0;
    if (z > RIGHT_ANGLE) begin
      z -= 2 * RIGHT_ANGLE;
      flip = 1'b1;
    end else if (z < -RIGHT_ANGLE) begin
      z += 2 * RIGHT_ANGLE;
      flip = 1'b1;
    end
    for (int i = 0; i < TRIG_STEPS && i < ATAN_LEN; i++) begin
      step_x = y >>> i;
      step_y = x >>> i;
      if (z >= 0) begin
        x -= step_x;
        y += step_y;
        z -= ATAN_DEG[i];
      end else begin
        x += step_x;
        y -= step_y;
        z += ATAN_DEG[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic logic signed [15:0] clamp_q15(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // advance the camera by one motion event and queue the view it should report
  function automatic void predict_orientation(input logic signed [15:0] dx,
                                              input logic signed [15:0] dy);
    longint t, m, sin_y, cos_y, sin_p, cos_p;
    view_t  v;
    t = cam_yaw + longint'(dx) * cam_sens + HALF_TURN;
    m = t % FULL_TURN;
    if (m < 0) m += FULL_TURN;
    cam_yaw = m - HALF_TURN;
    t = cam_pitch - longint'(dy) * cam_sens;
    if (t < -TILT_LIMIT) t = -TILT_LIMIT;
    if (t > TILT_LIMIT) t = TILT_LIMIT;
    cam_pitch = t;
    cordic_sincos(cam_yaw, sin_y, cos_y);
    cordic_sincos(cam_pitch, sin_p, cos_p);
    v.fwd_x = clamp_q15((cos_y * cos_p + (longint'(1) << 44)) >>> 45);
    v.fwd_y = clamp_q15((sin_p + (longint'(1) << 14)) >>> 15);
    v.fwd_z = clamp_q15((sin_y * cos_p + (longint'(1) << 44)) >>> 45);
    v.yaw = cam_yaw[24:0];
    v.pitch = cam_pitch[23:0];
    pending_views.push_back(v);
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // result checker and activity counter for the watchdog
  always @(posedge clk) begin
    view_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
          (cfg_valid && cfg_ready === 1'b1)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid === 1'b1 && !out_stall) begin
        if (pending_views.size() == 0) begin
          $error("orientation beat with nothing expected");
          mismatches++;
        end else begin
          want = pending_views.pop_front();
          check_field("forward_x", want.fwd_x, forward_x);
          check_field("forward_y", want.fwd_y, forward_y);
          check_field("forward_z", want.fwd_z, forward_z);
          check_field("yaw_now", want.yaw, yaw_now);
          check_field("pitch_now", want.pitch, pitch_now);
          results_checked++;
        end
      end
    end
  end

  // receiver back-pressure: none, random stalls 40 percent of the time, or runs of random length
  always @(posedge clk) begin
    case (rx_mode)
      RX_OPEN: begin
        out_stall <= 1'b0;
      end
      RX_CHOPPY: begin
        out_stall <= ($urandom_range(0, 99) < 40);
      end
      default: begin
        if (rx_run_left == 0) begin
          out_stall <= ~out_stall;
          rx_run_left <= $urandom_range(1, 12);
        end else begin
          rx_run_left <= rx_run_left - 1;
        end
      end
    endcase
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("mouse_look_orientation_tb: FAIL");
    $finish;
  end

  // one motion beat; in bursty mode a random gap follows the end of each burst
  task automatic send_motion(input logic signed [15:0] dx, input logic signed [15:0] dy);
    int gap;
    mouse_dx <= dx;
    mouse_dy <= dy;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_orientation(dx, dy);
    events_sent++;
    if (tx_mode == TX_BURSTY) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 24);
        burst_left = $urandom_range(0, 5);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // wait for every queued view, then let the pipeline settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_sensitivity(input logic [15:0] value);
    drain_results();
    sens_wdata <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    cam_sens = value;
    sens_settings++;
  endtask

  // mostly small hand motions, some medium, some full-range and edge values
  function automatic logic signed [15:0] pick_motion();
    int sel;
    logic signed [15:0] edges [5];
    edges = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0001, 16'shffff};
    sel = $urandom_range(0, 99);
    if (sel < 50) return 16'($signed($urandom_range(0, 128)) - 64);
    if (sel < 70) return 16'($signed($urandom_range(0, 4094)) - 2047);
    if (sel < 90) return 16'($urandom());
    return edges[$urandom_range(0, 4)];
  endfunction

  // first event after reset: default sensitivity, still motion
  task automatic test_after_reset();
    send_motion(16'sd0, 16'sd0);
  endtask

  // 0.625 degree per count: 144 counts is exactly a quarter turn
  task automatic test_quadrant_walk();
    set_sensitivity(16'd40960);
    send_motion(16'sd144, 16'sd0);     // yaw 0, pitch 0: full-scale forward_x
    send_motion(16'sd144, 16'sd0);     // yaw exactly +90, no fold
    send_motion(16'sd144, 16'sd0);     // +180 wraps to -180
    send_motion(16'sd144, 16'sd0);     // back to -90
    send_motion(16'sd0, -16'sd144);    // pitch past +89 clamps
    send_motion(16'sd0, 16'sd288);     // pitch past -89 clamps
    send_motion(-16'sd144, 16'sd142);  // yaw -180, pitch stays clamped at -89
  endtask

  // largest steps in both directions at the highest sensitivity
  task automatic test_field_extremes();
    set_sensitivity(16'hffff);
    send_motion(16'sh7fff, 16'sh7fff);
    send_motion(16'sh8000, 16'sh8000);
    send_motion(16'sh7fff, 16'sh8000);
    send_motion(16'sh8000, 16'sh7fff);
    send_motion(16'sd1, -16'sd1);
    send_motion(-16'sd1, 16'sd1);
  endtask

  task automatic test_sensitivity_extremes();
    set_sensitivity(16'd0);            // no motion at all
    send_motion(16'sd12345, -16'sd4321);
    send_motion(16'sh8000, 16'sh7fff);
    set_sensitivity(16'd1);            // finest step
    send_motion(16'sd1, 16'sd0);
    send_motion(-16'sd1, 16'sd0);
    send_motion(16'sh7fff, 16'sh7fff);
  endtask

  task automatic run_motion_phase(input logic [15:0] sens, input tx_mode_t tx,
                                  input rx_mode_t rx, input int count);
    set_sensitivity(sens);
    tx_mode = tx;
    rx_mode = rx;
    burst_left = 0;
    repeat (count) send_motion(pick_motion(), pick_motion());
  endtask

  task automatic test_random_motion();
    run_motion_phase(16'($urandom()), TX_STREAM, RX_OPEN, 400);
    run_motion_phase(16'($urandom_range(1000, 12000)), TX_BURSTY, RX_RUNS, 400);
    run_motion_phase(16'($urandom()), TX_BURSTY, RX_CHOPPY, 400);
    run_motion_phase(16'hffff, TX_BURSTY, RX_RUNS, 300);
    run_motion_phase(16'($urandom_range(1, 64)), TX_STREAM, RX_CHOPPY, 200);
    run_motion_phase(16'd0, TX_BURSTY, RX_OPEN, 200);
  endtask

  initial begin
    cam_yaw = -RIGHT_ANGLE;
    cam_pitch = 0;
    cam_sens = 6554;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_after_reset();
    test_quadrant_walk();
    test_field_extremes();
    test_sensitivity_extremes();
    test_random_motion();
    drain_results();
    $display("checked %0d orientation beats from %0d mouse events", results_checked,
             events_sent);
    $display("over %0d sensitivity writes, quadrant edges, clamps and idle patterns",
             sens_settings);
    if (mismatches == 0) begin
      $display("mouse_look_orientation_tb: PASS");
    end else begin
      $display("mouse_look_orientation_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: mouse_look_orientation.f
+incdir+rtl
rtl/mlo_pkg.sv
rtl/mlo_cordic.sv
rtl/mlo_datapath.sv
rtl/mlo_ctrl.sv
rtl/mouse_look_orientation.sv
rtl/mlo_checker.sv
tb/sv/mouse_look_orientation_tb.sv
